// ===== sv/b64d_pkg.sv =====
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the character classifier for the stream
// base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;

   localparam logic [5:0] SEXTET_LOWER_BASE = 6'd26;
   localparam logic [5:0] SEXTET_DIGIT_BASE = 6'd52;
   localparam logic [5:0] SEXTET_PLUS       = 6'd62;
   localparam logic [5:0] SEXTET_SLASH      = 6'd63;

   localparam logic [1:0] COUNT_ONE   = 2'd1;
   localparam logic [1:0] COUNT_TWO   = 2'd2;
   localparam logic [1:0] COUNT_THREE = 2'd3;

   typedef struct packed {
      logic       ok;
      logic [5:0] value;
   } sextet_type;

   // One burst of results caused by a single request.
   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      nbytes;
      logic            term;
   } burst_type;

   function automatic sextet_type sextet_of(input logic [7:0] c);
      sextet_type r;
      logic [7:0] d;
      r = '0;
      d = '0;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         d       = c - CHAR_UPPER_A;
         r.ok    = 1'b1;
         r.value = d[5:0];
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         d       = c - CHAR_LOWER_A;
         r.ok    = 1'b1;
         r.value = d[5:0] + SEXTET_LOWER_BASE;
      end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
         d       = c - CHAR_DIGIT_0;
         r.ok    = 1'b1;
         r.value = d[5:0] + SEXTET_DIGIT_BASE;
      end else if (c == CHAR_PLUS) begin
         r.ok    = 1'b1;
         r.value = SEXTET_PLUS;
      end else if (c == CHAR_SLASH) begin
         r.ok    = 1'b1;
         r.value = SEXTET_SLASH;
      end
      return r;
   endfunction

endpackage

// ===== sv/b64d_front.sv =====
// ----------------------------------------------------------------------------
// b64d_front
// Classifies each character, tracks the pending group and builds the burst
// of results that the character causes.
// ----------------------------------------------------------------------------
module b64d_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [7:0]          req_in_char,
   input  logic                req_string_last,
   input  logic                take,
   output logic                push,
   output b64d_pkg::burst_type push_data
);
   import b64d_pkg::*;

   logic [17:0] store_ff, store_in;
   logic [1:0]  count_ff, count_in;
   logic        stopped_ff, stopped_in;

   sextet_type  sx;
   logic [17:0] step_store;
   logic [1:0]  step_count;
   logic        step_stopped;
   logic [17:0] flush_store;
   logic [1:0]  flush_count;
   logic [23:0] word;

   always_comb begin
      sx           = sextet_of(req_in_char);
      word         = {store_ff, sx.value};
      step_store   = store_ff;
      step_count   = count_ff;
      step_stopped = stopped_ff;
      flush_store  = '0;
      flush_count  = '0;
      push_data    = '0;

      if (!stopped_ff) begin
         if (!sx.ok) begin
            flush_store  = store_ff;
            flush_count  = count_ff;
            step_store   = '0;
            step_count   = '0;
            step_stopped = 1'b1;
         end else if (count_ff == COUNT_THREE) begin
            push_data.bytes[0] = word[23:16];
            push_data.bytes[1] = word[15:8];
            push_data.bytes[2] = word[7:0];
            push_data.nbytes   = COUNT_THREE;
            step_store         = '0;
            step_count         = '0;
         end else begin
            step_store = {store_ff[11:0], sx.value};
            step_count = count_ff + COUNT_ONE;
         end
      end

      // On the last character the group left after this step is flushed.
      if (req_string_last && flush_count == 2'd0) begin
         flush_store = step_store;
         flush_count = step_count;
      end

      if (flush_count == COUNT_TWO) begin
         push_data.bytes[0] = flush_store[11:4];
         push_data.nbytes   = COUNT_ONE;
      end else if (flush_count == COUNT_THREE) begin
         push_data.bytes[0] = flush_store[17:10];
         push_data.bytes[1] = flush_store[9:2];
         push_data.nbytes   = COUNT_TWO;
      end

      push_data.term = req_string_last;

      if (req_string_last) begin
         store_in   = '0;
         count_in   = '0;
         stopped_in = 1'b0;
      end else begin
         store_in   = step_store;
         count_in   = step_count;
         stopped_in = step_stopped;
      end

      push = req_valid && take && (push_data.term || push_data.nbytes != 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff   <= '0;
         count_ff   <= '0;
         stopped_ff <= 1'b0;
      end else if (req_valid && take) begin
         store_ff   <= store_in;
         count_ff   <= count_in;
         stopped_ff <= stopped_in;
      end
   end

endmodule

// ===== sv/b64d_queue.sv =====
// ----------------------------------------------------------------------------
// b64d_queue
// Short queue of result bursts between the front and the back.
// ----------------------------------------------------------------------------
module b64d_queue #(
   parameter int DEPTH = b64d_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  b64d_pkg::burst_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output b64d_pkg::burst_type head_data
);
   import b64d_pkg::*;

   localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0] PtrLast = PtrWidth'(DEPTH - 1);
   localparam logic [CntWidth-1:0] CntFull = CntWidth'(DEPTH);

   burst_type             mem_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign full       = (count_ff == CntFull);
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/b64d_back.sv =====
// ----------------------------------------------------------------------------
// b64d_back
// Walks through the head burst one result per cycle into the output
// register, while a stalled rsp_ready does not hold that register.
// ----------------------------------------------------------------------------
module b64d_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  b64d_pkg::burst_type head_data,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_byte_valid,
   output logic                rsp_string_done,
   output logic                rsp_run_last
);
   import b64d_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       bvalid_ff, bvalid_in;
   logic       done_ff, done_in;
   logic       last_ff, last_in;
   logic       load;
   logic [2:0] total;
   logic       is_byte;
   logic       is_last;

   always_comb begin
      load    = !valid_ff || rsp_ready;
      total   = {1'b0, head_data.nbytes} + {2'b00, head_data.term};
      is_byte = (idx_ff < head_data.nbytes);
      is_last = ({1'b0, idx_ff} + 3'd1 == total);

      idx_in    = idx_ff;
      valid_in  = valid_ff;
      byte_in   = byte_ff;
      bvalid_in = bvalid_ff;
      done_in   = done_ff;
      last_in   = last_ff;
      pop       = 1'b0;

      if (load) begin
         valid_in = head_valid;
         if (head_valid) begin
            byte_in   = is_byte ? head_data.bytes[idx_ff] : 8'h00;
            bvalid_in = is_byte;
            done_in   = !is_byte;
            last_in   = is_last;
            if (is_last) begin
               pop    = 1'b1;
               idx_in = '0;
            end else begin
               idx_in = idx_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      bvalid_ff <= bvalid_in;
      done_ff   <= done_in;
      last_ff   <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_byte_valid  = bvalid_ff;
   assign rsp_string_done = done_ff;
   assign rsp_run_last    = last_ff;

endmodule

// ===== sv/base64_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Decodes a base64 character stream into bytes plus a terminator per string.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Payload
//  req_     | in        | in_char, string_last
//  rsp_     | out       | out_byte, byte_valid, string_done, run_last
//
// A character is taken every cycle while the burst queue has room; each
// one yields zero to four results, and the back end delivers one result per
// cycle unless rsp_ready stalls it, so the sustained rate is set by the
// result count of each character. Results go via the burst queue and the
// output register. Reset clears the group state, the queue and the output
// valid flag. A stalled rsp_ side fills the queue and req_ready drops.
module base64_stream_decoder #(
   parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_char,
   input  logic       req_string_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_string_done,
   output logic       rsp_run_last
);
   import b64d_pkg::*;

   burst_type push_data;
   burst_type head_data;
   logic      push, full, pop, head_valid;

   assign req_ready = !full;

   b64d_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_in_char     (req_in_char),
      .req_string_last (req_string_last),
      .take            (req_ready),
      .push            (push),
      .push_data       (push_data)
   );

   b64d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   b64d_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_data       (head_data),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_string_done (rsp_string_done),
      .rsp_run_last    (rsp_run_last)
   );

endmodule

// ===== tb/base64_stream_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// base64_stream_decoder_tb
// Self-checking bench for the stream base64 decoder. Characters go in one
// request at a time. A predictor in the bench tracks the pending group and the
// stop flag and queues the bytes and terminators that each request should
// produce. Every response is checked field by field against that queue.
// ----------------------------------------------------------------------------
module base64_stream_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import b64d_pkg::*;

   localparam logic [7:0] CHAR_PAD  = 8'h3D;
   localparam int         LONG_HOLD = 64;

   typedef struct packed {
      logic [7:0] data;
      logic       is_byte;
      logic       done;
      logic       run_end;
   } rsp_item_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_char = 8'h00;
   logic       req_string_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_valid;
   logic       rsp_string_done;
   logic       rsp_run_last;

   // Predictor state and the responses still owed by the block.
   logic [17:0]  model_sextets = '0;
   logic [1:0]   model_count = '0;
   logic         model_halted = 1'b0;
   rsp_item_type burst [4];
   int           burst_len;
   rsp_item_type expected_rsp [$];

   bit src_idles  = 1'b0;
   bit sink_idles = 1'b0;
   bit hold_sink  = 1'b0;
   int live_items = 0;
   int strings_sent = 0;
   int results_checked = 0;
   int errors = 0;

   base64_stream_decoder DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_char     (req_in_char),
      .req_string_last (req_string_last),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_string_done (rsp_string_done),
      .rsp_run_last    (rsp_run_last)
   );

   always #2 clock = ~clock;

   // Returns {is_alphabet, sextet}.
   function automatic logic [6:0] char_value(input logic [7:0] c);
      logic [7:0] d;
      d = 8'd0;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         d = c - CHAR_UPPER_A;
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         d = c - CHAR_LOWER_A + 8'd26;
      end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
         d = c - CHAR_DIGIT_0 + 8'd52;
      end else if (c == CHAR_PLUS) begin
         d = 8'd62;
      end else if (c == CHAR_SLASH) begin
         d = 8'd63;
      end else begin
         return 7'h00;
      end
      return {1'b1, d[5:0]};
   endfunction

   function automatic logic [7:0] sextet_char(input logic [5:0] v);
      if (v < 6'd26) return CHAR_UPPER_A + 8'(v);
      if (v < 6'd52) return CHAR_LOWER_A + 8'(v) - 8'd26;
      if (v < 6'd62) return CHAR_DIGIT_0 + 8'(v) - 8'd52;
      if (v == 6'd62) return CHAR_PLUS;
      return CHAR_SLASH;
   endfunction

   function automatic logic [7:0] random_alpha();
      return sextet_char(6'($urandom_range(0, 63)));
   endfunction

   function automatic void add_result(input logic [7:0] data, input logic is_byte,
                                      input logic done);
      burst[burst_len] = '{data, is_byte, done, 1'b0};
      burst_len++;
   endfunction

   // A partial group of two sextets holds one byte, three sextets hold two.
   function automatic void flush_group();
      if (model_count == COUNT_TWO) begin
         add_result(model_sextets[11:4], 1'b1, 1'b0);
      end else if (model_count == COUNT_THREE) begin
         add_result(model_sextets[17:10], 1'b1, 1'b0);
         add_result(model_sextets[9:2], 1'b1, 1'b0);
      end
      model_sextets = '0;
      model_count = '0;
   endfunction

   function automatic void decode_char(input logic [7:0] c, input logic last);
      logic [6:0]  cv;
      logic [23:0] word;
      cv = char_value(c);
      word = {model_sextets, cv[5:0]};
      burst_len = 0;
      if (!model_halted) begin
         if (!cv[6]) begin
            flush_group();
            model_halted = 1'b1;
         end else if (model_count == COUNT_THREE) begin
            add_result(word[23:16], 1'b1, 1'b0);
            add_result(word[15:8], 1'b1, 1'b0);
            add_result(word[7:0], 1'b1, 1'b0);
            model_sextets = '0;
            model_count = '0;
         end else begin
            model_sextets = word[17:0];
            model_count = model_count + 2'd1;
         end
      end
      if (last) begin
         if (!model_halted) flush_group();
         add_result(8'h00, 1'b0, 1'b1);
         model_sextets = '0;
         model_count = '0;
         model_halted = 1'b0;
      end
      if (burst_len > 0) burst[burst_len - 1].run_end = 1'b1;
      for (int i = 0; i < burst_len; i++) expected_rsp.push_back(burst[i]);
   endfunction

   // Valid is only lowered ahead of an idle gap, so it is never lowered and
   // raised within the same step.
   task automatic send_char(input logic [7:0] c, input logic last);
      if (src_idles && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_char <= c;
      req_string_last <= last;
      do @(posedge clock); while (!req_ready);
      live_items++;
      if (last) strings_sent++;
      decode_char(c, last);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
   endtask

   task automatic test_directed();
      src_idles = 1'b1;
      sink_idles = 1'b1;
      send_text("TWFu");
      send_text("QQ==");
      send_text("QUJ");
      send_text("A");
      send_text("+/Z9");
      // A high byte stops decoding; the character after it is ignored.
      send_char(CHAR_SLASH, 1'b0);
      send_char(CHAR_SLASH, 1'b0);
      send_char(8'hFF, 1'b0);
      send_char(CHAR_UPPER_A, 1'b1);
      send_char(CHAR_LOWER_Z, 1'b0);
      send_char(8'h00, 1'b1);
   endtask

   task automatic test_output_stall();
      src_idles = 1'b0;
      sink_idles = 1'b0;
      hold_sink = 1'b1;
      for (int i = 0; i < 24; i++) send_char(random_alpha(), i == 23);
   endtask

   task automatic test_random_strings(input int n_items);
      logic [7:0] chars [$];
      int start, kind, ngroups, tail, len, pos;
      start = live_items;
      while (live_items - start < n_items) begin
         chars.delete();
         kind = $urandom_range(0, 9);
         if (kind < 6) begin
            ngroups = $urandom_range(0, 3);
            tail = $urandom_range(0, 2);
            if (tail != 0) tail++;
            if (ngroups == 0 && tail == 0) tail = 2;
            repeat (4 * ngroups + tail) chars.push_back(random_alpha());
            if (tail != 0) repeat (4 - tail) chars.push_back(CHAR_PAD);
         end else if (kind < 8) begin
            len = $urandom_range(1, 10);
            pos = $urandom_range(0, len);
            for (int i = 0; i < len; i++) begin
               if (i == pos) begin
                  chars.push_back($urandom_range(0, 1) ? CHAR_PAD
                                                       : 8'($urandom_range(0, 255)));
               end
               chars.push_back(random_alpha());
            end
         end else begin
            repeat ($urandom_range(1, 8)) chars.push_back(8'($urandom_range(0, 255)));
         end
         // The closing stretch runs without idling on either side.
         if (live_items - start >= n_items - 60) begin
            src_idles = 1'b0;
            sink_idles = 1'b0;
         end else begin
            src_idles = ($urandom_range(0, 3) != 0);
            sink_idles = ($urandom_range(0, 3) != 0);
         end
         foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
      end
   endtask

   initial begin : sink
      forever begin
         @(posedge clock);
         if (hold_sink) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_sink = 1'b0;
            rsp_ready <= 1'b1;
         end else if (sink_idles && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            $display("%0t: response with none pending: byte %h valid %b done %b last %b",
                     $time, rsp_out_byte, rsp_byte_valid, rsp_string_done, rsp_run_last);
            errors++;
         end else begin
            want = expected_rsp.pop_front();
            results_checked++;
            if (rsp_out_byte !== want.data) begin
               $display("%0t: out_byte expected %h actual %h", $time, want.data, rsp_out_byte);
               errors++;
            end
            if (rsp_byte_valid !== want.is_byte) begin
               $display("%0t: byte_valid expected %b actual %b", $time, want.is_byte,
                        rsp_byte_valid);
               errors++;
            end
            if (rsp_string_done !== want.done) begin
               $display("%0t: string_done expected %b actual %b", $time, want.done,
                        rsp_string_done);
               errors++;
            end
            if (rsp_run_last !== want.run_end) begin
               $display("%0t: run_last expected %b actual %b", $time, want.run_end,
                        rsp_run_last);
               errors++;
            end
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_output_stall();
      test_random_strings(234);
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("Sent %0d requests in %0d strings: directed cases, a long output stall",
               live_items, strings_sent);
      $display("and random well-formed, broken and noise strings; %0d responses checked.",
               results_checked);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/b64d_pkg.sv
sv/b64d_front.sv
sv/b64d_queue.sv
sv/b64d_back.sv
sv/base64_stream_decoder.sv
tb/base64_stream_decoder_tb.sv
